/* design/dhss_pkg.sv */
// Package for the DNA string hash set: word types, field widths and codes.
// No dependencies.
`default_nettype none

package dhss_pkg;

  localparam int LEN_W         = 4;
  localparam int LET_W         = 22;
  localparam int FIELD_LETTERS = 11;
  localparam int MAX_LETTERS   = 11;
  localparam int LEN_CAP       = (MAX_LETTERS < FIELD_LETTERS) ? MAX_LETTERS : FIELD_LETTERS;
  // largest key is 4 * (2^11 - 1) = 8188
  localparam int KEY_W         = 13;
  localparam int ENTRY_W       = 1 + LEN_W + LET_W;
  localparam int VALID_BIT     = ENTRY_W - 1;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FIND   = 1'b1;

  typedef struct packed {
    logic             command;
    logic [LEN_W-1:0] length;
    logic [LET_W-1:0] letters;
  } dhss_in_t;

  typedef struct packed {
    logic found;
    logic inserted;
    logic full_res;
  } dhss_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic mod_step;
    logic rd;
    logic cmp;
    logic clr_step;
  } dhss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic key_ge_size;
    logic mod_last;
    logic hit;
    logic empty;
    logic last_probe;
    logic clr_last;
  } dhss_sts_t;

endpackage

`default_nettype wire

/* design/double_hash_string_set_top.sv */
// Top level of the DNA string hash set (open addressing, double hashing).
// Sequence: accept, setup, then the modulo steps when the key is not below
//   TABLE_SIZE, then per probe a memory read and a compare; the result is registered after the last compare.
// A new word is taken only once the previous one has finished; busy stays high meanwhile.
// Reset: synchronous; a clearing pass over every slot empties the table, busy high.
// The result strobe lasts one cycle; the receiver cannot stall. Depends on dhss_pkg.
`default_nettype none

module double_hash_string_set_top
  import dhss_pkg::*;
#(
  parameter int TABLE_SIZE = 8191
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  // command side: word taken when start is high and busy is low
  input  wire logic     start,
  output logic          busy,
  input  wire dhss_in_t in_word,
  // result side: one-cycle strobe per word
  output logic          out_valid,
  output dhss_out_t     out_word
);

  dhss_cmd_t cmd;
  dhss_sts_t sts;

  // sequencer: clear pass, setup, modulo and probe loop
  dhss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // key, probe address arithmetic and slot memory
  dhss_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

/* design/dhss_ctrl.sv */
// Controller FSM for the hash set: clear pass, setup, modulo, probe loop.
// Depends on dhss_pkg.
`default_nettype none

module dhss_ctrl
  import dhss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire dhss_sts_t sts,
  output dhss_cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.key_ge_size ? S_MOD : S_READ;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.hit || sts.empty || sts.last_probe) state_nxt = S_IDLE;
        else                                        state_nxt = S_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

/* design/dhss_dp.sv */
// Datapath for the hash set: key build, reciprocal modulo, probe address, slot memory.
// Depends on dhss_pkg.
`default_nettype none

module dhss_dp
  import dhss_pkg::*;
#(
  parameter int TABLE_SIZE = 8191
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire dhss_in_t  in_word,
  input  wire dhss_cmd_t cmd,
  output dhss_sts_t      sts,
  output logic           out_valid,
  output dhss_out_t      out_word
);

  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int SW  = $clog2(TABLE_SIZE + 1);
  localparam int CW  = (KEY_W > SW) ? KEY_W : SW;
  // key / TABLE_SIZE as (key * MOD_M) >> MOD_S, exact for every KEY_W-bit key
  localparam int              MOD_S   = KEY_W + AW;
  localparam int              MW      = KEY_W + 2;
  localparam int              PW      = KEY_W + MW;
  localparam logic [63:0]     MOD_M64 = ((64'd1 << MOD_S) + 64'(TABLE_SIZE) - 64'd1) /
                                        64'(TABLE_SIZE);
  localparam logic [MW-1:0]   MOD_M   = MW'(MOD_M64);

  logic [ENTRY_W-1:0] mem [TABLE_SIZE];

  logic [ENTRY_W-1:0] entry_r, entry_nxt;
  logic [ENTRY_W-1:0] rd_data_r;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic               cmd_r, cmd_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      step_r, step_nxt;
  logic [SW-1:0]      cnt_r, cnt_nxt;
  logic [KEY_W-1:0]   q_r, q_nxt;
  logic               mcnt_r, mcnt_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  dhss_out_t          out_word_r, out_word_nxt;

  logic [LEN_W-1:0]   eff_len;
  logic [LET_W-1:0]   bits_m;
  logic [KEY_W-1:0]   key_in;
  logic [CW-1:0]      key_ext;
  logic [CW:0]        step_raw;
  logic [PW-1:0]      mod_prod;
  logic [KEY_W-1:0]   mod_qs;
  logic [KEY_W-1:0]   mod_rem;
  logic [AW:0]        pos_sum;
  logic               done;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // effective length, masked letters and key of the incoming word
  always_comb begin
    eff_len = (in_word.length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_word.length;
    bits_m  = '0;
    key_in  = '0;
    for (int j = 0; j < FIELD_LETTERS; j++) begin
      if (LEN_W'(j) < eff_len) begin
        bits_m[2*j +: 2] = in_word.letters[2*j +: 2];
        key_in = key_in + (KEY_W'({1'b0, in_word.letters[2*j +: 2]} + 3'd1) << j);
      end
    end
  end

  assign key_ext  = CW'(key_r);
  assign step_raw = {1'b0, key_ext & CW'(TABLE_SIZE - 1)} + (CW + 1)'(1);
  assign pos_sum  = {1'b0, pos_r} + {1'b0, step_r};

  // remainder is below 2^KEY_W, so the product only needs its low KEY_W bits
  assign mod_prod = PW'(key_r) * PW'(MOD_M);
  assign mod_qs   = q_r * KEY_W'(TABLE_SIZE);
  assign mod_rem  = key_r - mod_qs;

  assign sts.key_ge_size = (key_ext >= CW'(TABLE_SIZE));
  assign sts.mod_last    = mcnt_r;
  assign sts.hit         = (rd_data_r == entry_r);
  assign sts.empty       = !rd_data_r[VALID_BIT];
  assign sts.last_probe  = ({1'b0, cnt_r} + (SW + 1)'(1)) == (SW + 1)'(TABLE_SIZE);
  assign sts.clr_last    = (clr_addr_r == AW'(TABLE_SIZE - 1));

  assign done = cmd.cmp && (sts.hit || sts.empty || sts.last_probe);

  always_comb begin
    entry_nxt     = entry_r;
    key_nxt       = key_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    mcnt_nxt      = mcnt_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;

    if (cmd.load) begin
      entry_nxt = {1'b1, eff_len, bits_m};
      key_nxt   = key_in;
      cmd_nxt   = in_word.command;
    end

    if (cmd.prep) begin
      step_nxt = (step_raw == (CW + 1)'(TABLE_SIZE)) ? '0 : AW'(step_raw);
      pos_nxt  = AW'(key_ext);
      cnt_nxt  = '0;
      mcnt_nxt = 1'b0;
    end

    // modulo: quotient by reciprocal multiply into q_r, then key - q*size into the position
    if (cmd.mod_step) begin
      q_nxt    = KEY_W'(mod_prod >> MOD_S);
      mcnt_nxt = 1'b1;
      if (sts.mod_last) pos_nxt = AW'(mod_rem);
    end

    if (cmd.cmp) begin
      if (done) begin
        out_valid_nxt         = 1'b1;
        out_word_nxt.found    = sts.hit;
        out_word_nxt.inserted = !sts.hit && sts.empty && (cmd_r == CMD_INSERT);
        out_word_nxt.full_res = !sts.hit && !sts.empty;
      end else begin
        pos_nxt = (pos_sum >= (AW + 1)'(TABLE_SIZE)) ? AW'(pos_sum - (AW + 1)'(TABLE_SIZE))
                                                     : AW'(pos_sum);
        cnt_nxt = cnt_r + SW'(1);
      end
    end

    if (cmd.clr_step) clr_addr_nxt = clr_addr_r + AW'(1);
  end

  // single write port: clear pass or insert into an empty slot
  always_comb begin
    wr_en   = cmd.clr_step ||
              (cmd.cmp && !sts.hit && sts.empty && (cmd_r == CMD_INSERT));
    wr_addr = cmd.clr_step ? clr_addr_r : pos_r;
    wr_data = cmd.clr_step ? '0 : entry_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.rd) rd_data_r <= mem[pos_r];
  end

  always_ff @(posedge clk) begin
    entry_r    <= entry_nxt;
    key_r      <= key_nxt;
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    step_r     <= step_nxt;
    cnt_r      <= cnt_nxt;
    q_r        <= q_nxt;
    mcnt_r     <= mcnt_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_addr_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      clr_addr_r  <= clr_addr_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
